[hdl/decimal_text_to_integer_with_suffix_core_macros.svh]
// assertion macros shared by the decimal parser rtl
// needs i_clk and i_rst_n in the scope of each use
`ifndef DECIMAL_TEXT_TO_INTEGER_WITH_SUFFIX_CORE_MACROS_SVH
`define DECIMAL_TEXT_TO_INTEGER_WITH_SUFFIX_CORE_MACROS_SVH

// condition must hold on every clock edge out of reset
`define DTIS_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DTIS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define DTIS_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[hdl/dtis_pkg.sv]
// shared types and constants for the decimal text to integer parser
// no dependencies
package dtis_pkg;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned HALF_W  = 32;
    localparam int unsigned COEF_W  = 28;

    // exponent of the 125^n factor left after a 1000^n suffix is split into 8^n * 125^n
    typedef logic [2:0] t_pow_sel;

    typedef struct packed {
        logic [VALUE_W-1:0] val;
        t_pow_sel           sel;
    } t_scale_req;

    function automatic logic [COEF_W-1:0] pow125(input t_pow_sel sel);
        logic [COEF_W-1:0] coef;
        case (sel)
            3'd1:    coef = 28'd125;
            3'd2:    coef = 28'd15625;
            3'd3:    coef = 28'd1953125;
            3'd4:    coef = 28'd244140625;
            default: coef = 28'd1;
        endcase
        return coef;
    endfunction

endpackage

[hdl/dtis_scale.sv]
// two-stage constant multiply that applies the pending 125^n factor
// depends on dtis_pkg
module dtis_scale (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_vld,
    input  dtis_pkg::t_scale_req       i_req,
    output logic                       o_req_rdy,
    output logic                       o_value_vld,
    output logic [dtis_pkg::VALUE_W-1:0] o_value,
    input  logic                       i_value_rdy
);
    import dtis_pkg::*;

    logic                      r_s1_vld;
    t_scale_req                r_s1;
    logic                      r_s2_vld;
    logic [HALF_W+COEF_W-1:0]  r_p_lo;
    logic [HALF_W-1:0]         r_p_hi;
    logic                      r_out_vld;
    logic [VALUE_W-1:0]        r_out;

    logic                      s1_rdy;
    logic                      s2_rdy;
    logic                      s3_rdy;
    logic [COEF_W-1:0]         coef;
    logic [HALF_W+COEF_W-1:0]  n_p_lo;
    logic [HALF_W-1:0]         n_p_hi;
    logic [VALUE_W-1:0]        n_out;

    always_comb begin
        s3_rdy    = !r_out_vld || i_value_rdy;
        s2_rdy    = !r_s2_vld || s3_rdy;
        s1_rdy    = !r_s1_vld || s2_rdy;
        coef      = pow125(r_s1.sel);
        n_p_lo    = r_s1.val[HALF_W-1:0] * coef;
        // only the low half of the upper product lands below bit 64
        n_p_hi    = HALF_W'(r_s1.val[VALUE_W-1:HALF_W] * coef);
        n_out     = {{(VALUE_W-HALF_W-COEF_W){1'b0}}, r_p_lo} + {r_p_hi, {HALF_W{1'b0}}};
    end

    assign o_req_rdy   = s1_rdy;
    assign o_value_vld = r_out_vld;
    assign o_value     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_rdy) begin
                r_s1_vld <= i_req_vld;
            end
            if (s2_rdy) begin
                r_s2_vld <= r_s1_vld;
            end
            if (s3_rdy) begin
                r_out_vld <= r_s2_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_rdy) begin
            r_s1 <= i_req;
        end
        if (s2_rdy) begin
            r_p_lo <= n_p_lo;
            r_p_hi <= n_p_hi;
        end
        if (s3_rdy) begin
            r_out <= n_out;
        end
    end

endmodule

[hdl/decimal_text_to_integer_with_suffix_core.sv]
// top level of the decimal text to integer parser with size suffixes
// depends on dtis_pkg, dtis_scale and the shared assertion macros
//
// usage:
//   s_axis carries one character per transaction: tdata[7:0] is the ascii
//   code, tlast marks the final character of the string. m_axis carries one
//   64-bit value per string, emitted for the character flagged tlast.
//   i_cfg_we/i_cfg_wdata write suffix_enable; change it only while idle.
// throughput: one character per cycle when not stalled. digits update the
//   accumulator with a shift-add; a suffix is applied as a shift at once and
//   its 125^n factor is folded in by a two-stage 32x28 multiply on the way out.
// path: after the last character's transaction the value passes the input
//   register, two multiply stages and the output register to reach m_axis.
// reset: i_rst_n is synchronous, active low; it clears the accumulator, the
//   stop flag, suffix_enable and all valid flags.
// stall: when m_axis_tready is low the pipeline fills and then s_axis_tready
//   drops; non-last characters keep draining since they make no result.
`include "decimal_text_to_integer_with_suffix_core_macros.svh"

module decimal_text_to_integer_with_suffix_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_wdata,    // suffix_enable
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [7:0] char_code
    input  logic                         s_axis_tlast,   // last_char
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [dtis_pkg::VALUE_W-1:0] m_axis_tdata    // [63:0] value
);
    import dtis_pkg::*;

    localparam logic [7:0] C_CH_0  = 8'h30;
    localparam logic [7:0] C_CH_9  = 8'h39;
    localparam logic [7:0] C_CH_UK = 8'h4B;
    localparam logic [7:0] C_CH_UM = 8'h4D;
    localparam logic [7:0] C_CH_UG = 8'h47;
    localparam logic [7:0] C_CH_UT = 8'h54;
    localparam logic [7:0] C_CH_LK = 8'h6B;
    localparam logic [7:0] C_CH_LM = 8'h6D;
    localparam logic [7:0] C_CH_LG = 8'h67;
    localparam logic [7:0] C_CH_LT = 8'h74;

    logic               r_sfx_en;
    logic               r_in_vld;
    logic [7:0]         r_in_char;
    logic               r_in_last;
    logic [VALUE_W-1:0] r_acc;
    logic               r_stopped;
    t_pow_sel           r_sel;

    logic               s0_go;
    logic               is_digit;
    logic [3:0]         ch_off;
    logic [VALUE_W-1:0] n_acc;
    logic               n_stopped;
    t_pow_sel           n_sel;
    t_scale_req         sc_req;
    logic               sc_vld;
    logic               sc_rdy;

    always_comb begin
        s0_go         = r_in_vld && (!r_in_last || sc_rdy);
        s_axis_tready = !r_in_vld || s0_go;
        is_digit      = (r_in_char >= C_CH_0) && (r_in_char <= C_CH_9);
        ch_off        = 4'(r_in_char - C_CH_0);
        n_acc         = r_acc;
        n_stopped     = r_stopped;
        n_sel         = r_sel;
        if (!r_stopped) begin
            if (is_digit) begin
                n_acc = (r_acc << 3) + (r_acc << 1)
                      + {{(VALUE_W-4){1'b0}}, ch_off};
            end else begin
                n_stopped = 1'b1;
                // binary suffixes are pure shifts; decimal ones shift by 3n and leave 125^n
                if (r_acc != '0 && r_sfx_en) begin
                    unique case (r_in_char)
                        C_CH_UK: n_acc = r_acc << 10;
                        C_CH_UM: n_acc = r_acc << 20;
                        C_CH_UG: n_acc = r_acc << 30;
                        C_CH_UT: n_acc = r_acc << 40;
                        C_CH_LK: begin
                            n_acc = r_acc << 3;
                            n_sel = 3'd1;
                        end
                        C_CH_LM: begin
                            n_acc = r_acc << 6;
                            n_sel = 3'd2;
                        end
                        C_CH_LG: begin
                            n_acc = r_acc << 9;
                            n_sel = 3'd3;
                        end
                        C_CH_LT: begin
                            n_acc = r_acc << 12;
                            n_sel = 3'd4;
                        end
                        default: n_acc = r_acc;
                    endcase
                end
            end
        end
        sc_req.val = n_acc;
        sc_req.sel = n_sel;
        sc_vld     = s0_go && r_in_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sfx_en  <= 1'b0;
            r_in_vld  <= 1'b0;
            r_acc     <= '0;
            r_stopped <= 1'b0;
            r_sel     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_sfx_en <= i_cfg_wdata;
            end
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (s0_go) begin
                if (r_in_last) begin
                    r_acc     <= '0;
                    r_stopped <= 1'b0;
                    r_sel     <= '0;
                end else begin
                    r_acc     <= n_acc;
                    r_stopped <= n_stopped;
                    r_sel     <= n_sel;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    dtis_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_vld   (sc_vld),
        .i_req       (sc_req),
        .o_req_rdy   (sc_rdy),
        .o_value_vld (m_axis_tvalid),
        .o_value     (m_axis_tdata),
        .i_value_rdy (m_axis_tready)
    );

    `DTIS_ASSERT_ALWAYS(a_sel_only_when_stopped, r_stopped || (r_sel == '0),
        "pending decimal scale without stop")
    `DTIS_ASSERT_SAME(a_nonlast_never_stalls, r_in_vld && !r_in_last, s0_go,
        "non-last character held in input register")
    `DTIS_ASSERT_NEXT(a_clear_after_last, s0_go && r_in_last,
        !r_stopped && (r_acc == '0) && (r_sel == '0),
        "parser state not cleared after last character")
    `DTIS_ASSERT_NEXT(a_stopped_holds, s0_go && r_stopped && !r_in_last,
        $stable(r_acc) && $stable(r_sel) && r_stopped,
        "accumulator changed after parsing stopped")

endmodule

[test/tb_decimal_text_to_integer_with_suffix_core.sv]
// testbench for decimal_text_to_integer_with_suffix_core: directed and random strings
// checked against an in-bench parser model; depends on dtis_pkg and the core rtl
`timescale 1ns / 1ps

module tb_decimal_text_to_integer_with_suffix_core;

    import dtis_pkg::*;

    localparam int unsigned IDLE_LIMIT   = 5000;
    localparam int unsigned DRAIN_CYCLES = 16;

    localparam logic [7:0] CH_ZERO = "0";
    localparam logic [7:0] CH_NINE = "9";
    localparam logic [7:0] CH_KB   = "K";
    localparam logic [7:0] CH_MB   = "M";
    localparam logic [7:0] CH_GB   = "G";
    localparam logic [7:0] CH_TB   = "T";
    localparam logic [7:0] CH_KD   = "k";
    localparam logic [7:0] CH_MD   = "m";
    localparam logic [7:0] CH_GD   = "g";
    localparam logic [7:0] CH_TD   = "t";

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_wdata;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata;   // [7:0] char_code
    logic               s_axis_tlast;   // last_char
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [VALUE_W-1:0] m_axis_tdata;   // [63:0] value

    // parser model state
    logic [VALUE_W-1:0] accum;
    bit                 parse_stopped;
    bit                 suffix_en;
    logic [VALUE_W-1:0] expected_values[$];

    int unsigned mismatches   = 0;
    int unsigned sent_chars   = 0;
    int unsigned idle_cycles  = 0;
    bit          calm         = 1'b0;

    decimal_text_to_integer_with_suffix_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [VALUE_W-1:0] scale_value(input logic [VALUE_W-1:0] x,
                                                       input logic [VALUE_W-1:0] base,
                                                       input int unsigned n);
        logic [VALUE_W-1:0] r;
        r = x;
        for (int unsigned i = 0; i < n; i++) r = r * base;
        return r;
    endfunction

    // updates the model for one accepted character, queues the value on the last one
    function automatic void parse_char(input logic [7:0] c, input logic last);
        if (!parse_stopped) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                accum = accum * 64'd10 + 64'(c - CH_ZERO);
            end else begin
                // a suffix after a zero value only stops parsing
                if (accum != '0 && suffix_en) begin
                    case (c)
                        CH_KB:   accum = scale_value(accum, 64'd1024, 1);
                        CH_MB:   accum = scale_value(accum, 64'd1024, 2);
                        CH_GB:   accum = scale_value(accum, 64'd1024, 3);
                        CH_TB:   accum = scale_value(accum, 64'd1024, 4);
                        CH_KD:   accum = scale_value(accum, 64'd1000, 1);
                        CH_MD:   accum = scale_value(accum, 64'd1000, 2);
                        CH_GD:   accum = scale_value(accum, 64'd1000, 3);
                        CH_TD:   accum = scale_value(accum, 64'd1000, 4);
                        default: ;
                    endcase
                end
                parse_stopped = 1'b1;
            end
        end
        if (last) begin
            expected_values.push_back(accum);
            accum         = '0;
            parse_stopped = 1'b0;
        end
    endfunction

    // valid stays high after a transaction; between items it drops only for random gaps unless calm is set
    task automatic send_char(input logic [7:0] c, input logic last);
        while (!calm && $urandom_range(99) < 7) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_chars++;
        parse_char(c, last);
    endtask

    task automatic send_bytes(input logic [7:0] text[$]);
        foreach (text[i]) send_char(text[i], i == text.size() - 1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    // register writes only once the pipeline has drained
    task automatic set_suffix(input bit en);
        s_axis_tvalid <= 1'b0;
        while (expected_values.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= en;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        suffix_en = en;
    endtask

    task automatic make_random_text(output logic [7:0] text[$]);
        logic [7:0]  suffixes[8];
        string       wrap_str;
        int unsigned kind;
        int unsigned n;
        suffixes = '{CH_KB, CH_MB, CH_GB, CH_TB, CH_KD, CH_MD, CH_GD, CH_TD};
        wrap_str = "18446744073709551616";
        text     = {};
        kind     = $urandom_range(99);
        if (kind < 70) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 6);
            repeat (n) text.push_back(CH_ZERO + 8'($urandom_range(9)));
            if ($urandom_range(9) < 7)
                text.push_back(suffixes[$urandom_range(7)]);
            else if ($urandom_range(1) == 0)
                text.push_back(8'($urandom_range(255)));
            repeat ($urandom_range(2)) text.push_back(8'($urandom_range(255)));
        end else if (kind < 78) begin
            // digits that wrap to exactly zero, then maybe a suffix
            for (int i = 0; i < wrap_str.len(); i++) text.push_back(wrap_str[i]);
            if ($urandom_range(1) == 0) text.push_back(suffixes[$urandom_range(7)]);
        end else if (kind < 88) begin
            text.push_back(($urandom_range(1) == 0) ? suffixes[$urandom_range(7)]
                                                    : 8'($urandom_range(255)));
            repeat ($urandom_range(3)) text.push_back(CH_ZERO + 8'($urandom_range(9)));
        end else begin
            repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic test_suffix_disabled();
        set_suffix(1'b0);
        send_text("4k");
        send_char(8'hFF, 1'b1);
    endtask

    task automatic test_suffix_scaling();
        set_suffix(1'b1);
        send_text("9T");
        send_text("1g");
        send_text("0K");
        send_text("K");
    endtask

    task automatic test_stop_chars();
        send_text("3x9");
        send_char("2", 1'b0);
        send_char(8'h00, 1'b1);
    endtask

    task automatic test_overflow();
        send_text("99999999t");
    endtask

    task automatic test_random();
        logic [7:0]  text[$];
        int unsigned goal;
        for (int phase = 0; phase < 6; phase++) begin
            set_suffix((phase == 0) ? 1'b0 : (phase == 1) ? 1'b1 : 1'($urandom_range(1)));
            calm = (phase == 3);
            goal = sent_chars + 115;
            while (sent_chars < goal) begin
                make_random_text(text);
                send_bytes(text);
            end
        end
        calm = 1'b0;
    endtask

    // receiver side stalls
    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 7);
    end

    always @(posedge i_clk) begin
        logic [VALUE_W-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_values.size() == 0) begin
                $error("value: expected none, actual %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_values.pop_front();
                if (m_axis_tdata !== want) begin
                    $error("value: expected %h, actual %h", want, m_axis_tdata);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("decimal_text_to_integer_with_suffix_core: mismatch");
            $finish;
        end
    end

    initial begin
        accum         = '0;
        parse_stopped = 1'b0;
        suffix_en     = 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_suffix_disabled();
        test_suffix_scaling();
        test_stop_chars();
        test_overflow();
        test_random();

        s_axis_tvalid <= 1'b0;
        while (expected_values.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("decimal_text_to_integer_with_suffix_core: match");
        else
            $display("decimal_text_to_integer_with_suffix_core: mismatch");
        $finish;
    end

endmodule
